/* src/wtdf_pkg.sv */
// Shared types, constants and ring-index helper for the windowed twin delivery filter.
// No dependencies; every other file of the block depends on this package.
package wtdf_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 64;
  localparam int CHAN_W      = 32;
  localparam int TIME_W      = 48;
  localparam int WIN_W       = 16;

  localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(2000);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [WIN_W-1:0]  win_t;

  typedef struct packed {
    key_t   key;
    chan_t  chan;
    stamp_t stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_SCAN,
    ST_SH_RD,
    ST_SH_WR,
    ST_APPEND,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the incoming transaction, clear scan index
    logic rd_head;     // read the oldest entry
    logic pop;         // drop the oldest entry
    logic scan_rd;     // read entry at scan index, advance index
    logic match_back;  // step index back onto the matching entry
    logic shift_rd;    // read entry above the hole
    logic shift_wr;    // write it into the hole, advance index
    logic drop_last;   // shrink the store by one after the shift
    logic set_dup;     // flag the result as duplicate
    logic append;      // write the latched item at the tail
    logic emit;        // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic expired;
    logic match;
    logic scan_done;
    logic shift_end;
    logic out_busy;
  } sts_t;

  // Add an offset to a ring position, wrapping at the store depth
  function automatic idx_t ring_add(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(MAX_ENTRIES)) begin
      sum = sum - (IDX_W+1)'(MAX_ENTRIES);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* src/wtdf_if.sv */
// Channel interfaces of the filter: input items, results and the window register write.
// Depends on wtdf_pkg for the payload types.
interface wtdf_in_if;
  logic             valid;
  logic             ready;
  logic             eligible;
  wtdf_pkg::key_t   entry_key;
  wtdf_pkg::chan_t  channel_tag;
  wtdf_pkg::stamp_t now_ms;

  modport source (output valid, eligible, entry_key, channel_tag, now_ms, input ready);
  modport sink   (input valid, eligible, entry_key, channel_tag, now_ms, output ready);
endinterface

interface wtdf_out_if;
  logic valid;
  logic ready;
  logic duplicate;

  modport source (output valid, duplicate, input ready);
  modport sink   (input valid, duplicate, output ready);
endinterface

interface wtdf_cfg_if;
  logic           valid;
  logic           ready;
  wtdf_pkg::win_t window_ms;

  modport source (output valid, window_ms, input ready);
  modport sink   (input valid, window_ms, output ready);
endinterface

/* src/windowed_twin_delivery_filter.sv */
// Top level of the windowed twin delivery filter: controller plus datapath.
// Depends on wtdf_pkg, the channel interfaces, wtdf_ctrl and wtdf_dp.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   in_ch    | in  | valid / ready | eligible, entry_key, channel_tag, now_ms
//   out_ch   | out | valid / ready | duplicate
//   cfg_ch   | in  | valid / ready | window_ms (ready always high)
//
// Sequence (accept edge to result-register load; the entry memory has one read port):
//   an ineligible item goes straight to the result; an eligible one pops expired entries
//   from the head, scans the kept entries and appends the item, then loads the result; a twin
//   is instead removed by shifting the entries above it down one place, with no append.
// Reset: rst_n low clears head, count and the output register and loads window_ms with 2000.
// Stalls: one transaction at a time; a result held by out_ch.ready stalls only the next one.
module windowed_twin_delivery_filter (
  input  logic       clk,
  input  logic       rst_n,
  wtdf_in_if.sink    in_ch,
  wtdf_out_if.source out_ch,
  wtdf_cfg_if.sink   cfg_ch
);
  import wtdf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Sequence the work of one transaction
  wtdf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_eligible (in_ch.eligible),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Hold entries, compare, and register the result
  wtdf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_entry_key   (in_ch.entry_key),
    .in_channel_tag (in_ch.channel_tag),
    .in_now_ms      (in_ch.now_ms),
    .cmd            (cmd),
    .sts            (sts),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch)
  );

  assign in_ch.ready = in_ready;

  // A result loaded into the output register must show as valid next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented on out_ch");

  // Only one transaction is in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  // The compaction write and the append never compete for the write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.shift_wr, cmd.append}))
    else $error("two writers on the entry memory");

  // Loading a transaction never coincides with store updates
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.pop || cmd.append || cmd.drop_last || cmd.emit))
    else $error("store updated while loading a transaction");

endmodule

/* src/wtdf_ctrl.sv */
// Controller state machine: sequences expiry, scan, compaction, append and result.
// Depends on wtdf_pkg for state, command and status types.
module wtdf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_eligible,
  output logic           in_ready,
  input  wtdf_pkg::sts_t sts,
  output wtdf_pkg::cmd_t cmd
);
  import wtdf_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;  // a scan read was issued last cycle

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_eligible ? ST_EXP_RD : ST_RESP;
        end
      end
      ST_EXP_RD:  state_nxt = sts.cnt_zero ? ST_SCAN : ST_EXP_CHK;
      ST_EXP_CHK: state_nxt = sts.expired ? ST_EXP_RD : ST_SCAN;
      ST_SCAN: begin
        if (pend_r && sts.match) begin
          state_nxt = ST_SH_RD;
        end else if (sts.scan_done) begin
          state_nxt = ST_APPEND;
        end
      end
      ST_SH_RD:  state_nxt = sts.shift_end ? ST_RESP : ST_SH_WR;
      ST_SH_WR:  state_nxt = ST_SH_RD;
      ST_APPEND: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXP_RD:  cmd.rd_head = !sts.cnt_zero;
      ST_EXP_CHK: cmd.pop = sts.expired;
      ST_SCAN: begin
        if (pend_r && sts.match) begin
          cmd.match_back = 1'b1;
        end else if (!sts.scan_done) begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_SH_RD: begin
        if (sts.shift_end) begin
          cmd.drop_last = 1'b1;
          cmd.set_dup   = 1'b1;
        end else begin
          cmd.shift_rd = 1'b1;
        end
      end
      ST_SH_WR:  cmd.shift_wr = 1'b1;
      ST_APPEND: cmd.append = 1'b1;
      ST_RESP:   cmd.emit = !sts.out_busy;
      default:   cmd = '0;
    endcase
  end

  assign pend_nxt = cmd.scan_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

/* src/wtdf_dp.sv */
// Datapath: ring-ordered entry memory, head/count/index registers, window register,
// comparators and the output register. Depends on wtdf_pkg and the channel interfaces.
module wtdf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  wtdf_pkg::key_t   in_entry_key,
  input  wtdf_pkg::chan_t  in_channel_tag,
  input  wtdf_pkg::stamp_t in_now_ms,
  input  wtdf_pkg::cmd_t   cmd,
  output wtdf_pkg::sts_t   sts,
  wtdf_out_if.source       out_ch,
  wtdf_cfg_if.sink         cfg_ch
);
  import wtdf_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_q;

  win_t   window_r;
  key_t   key_r;
  chan_t  chan_r;
  stamp_t now_r;
  logic   dup_r, dup_nxt;
  idx_t   head_r, head_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   idx_r, idx_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_dup_r;

  cnt_t   idx_p1;
  logic   full;
  idx_t   one_idx;
  idx_t   rd_addr, wr_addr;
  logic   rd_en, wr_en;
  entry_t wr_data;
  stamp_t age;

  assign idx_p1  = idx_r + CNT_W'(1);
  assign full    = (count_r == CNT_W'(MAX_ENTRIES));
  assign one_idx = IDX_W'(1);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    dup_nxt   = dup_r;
    if (cmd.load) begin
      idx_nxt = '0;
      dup_nxt = 1'b0;
    end
    if (cmd.pop) begin
      head_nxt  = ring_add(head_r, one_idx);
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.scan_rd || cmd.shift_wr) begin
      idx_nxt = idx_p1;
    end
    if (cmd.match_back) begin
      idx_nxt = idx_r - CNT_W'(1);
    end
    if (cmd.drop_last) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.set_dup) begin
      dup_nxt = 1'b1;
    end
    if (cmd.append) begin
      if (full) begin
        head_nxt = ring_add(head_r, one_idx);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // One read port, one write port
  always_comb begin
    rd_en   = cmd.rd_head || cmd.scan_rd || cmd.shift_rd;
    rd_addr = head_r;
    if (cmd.scan_rd) begin
      rd_addr = ring_add(head_r, idx_r[IDX_W-1:0]);
    end else if (cmd.shift_rd) begin
      rd_addr = ring_add(head_r, idx_p1[IDX_W-1:0]);
    end
    wr_en = cmd.shift_wr || cmd.append;
    if (cmd.shift_wr) begin
      wr_addr = ring_add(head_r, idx_r[IDX_W-1:0]);
      wr_data = rd_q;
    end else begin
      wr_addr = full ? head_r : ring_add(head_r, count_r[IDX_W-1:0]);
      wr_data = '{key: key_r, chan: chan_r, stamp: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign age           = now_r - rd_q.stamp;
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.expired   = (now_r >= rd_q.stamp) && (age > TIME_W'(window_r));
  assign sts.match     = (rd_q.key == key_r) && (rd_q.chan != chan_r);
  assign sts.scan_done = (idx_r == count_r);
  assign sts.shift_end = (idx_p1 == count_r);
  assign sts.out_busy  = out_valid_r && !out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_entry_key;
      chan_r <= in_channel_tag;
      now_r  <= in_now_ms;
    end
    if (cmd.emit) begin
      out_dup_r <= dup_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RST;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        window_r <= cfg_ch.window_ms;
      end
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.duplicate = out_dup_r;

endmodule
